// ===== rtl/eadp_pkg.sv =====
// Shared types and constants for the ELD audio descriptor parser.
// Used by eadp_sad_decode and eld_audio_descriptor_parser; no dependencies.
package eadp_pkg;

    // header layout and limits
    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned NAME_MAX     = 16;
    localparam int unsigned POS_W        = 9;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // header byte positions
    localparam logic [POS_W-1:0] POS_VERSION  = 9'd0;
    localparam logic [POS_W-1:0] POS_NAME_LEN = 9'd4;
    localparam logic [POS_W-1:0] POS_SAD_CNT  = 9'd5;
    localparam logic [POS_W-1:0] POS_DELAY    = 9'd6;
    localparam logic [POS_W-1:0] POS_SPEAKER  = 9'd7;

    // accepted version codes
    localparam logic [4:0] VER_861D    = 5'd2;
    localparam logic [4:0] VER_PARTIAL = 5'd31;

    // summary status codes
    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_BAD_VER   = 2'd1;
    localparam logic [1:0] ST_BAD_NAME  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // audio coding types
    localparam logic [3:0] FMT_LPCM    = 4'd1;
    localparam logic [3:0] FMT_CMP_LO  = 4'd2;
    localparam logic [3:0] FMT_CMP_HI  = 4'd8;
    localparam logic [3:0] FMT_WMA_PRO = 4'd14;
    localparam logic [3:0] FMT_EXT     = 4'd15;
    localparam logic [4:0] EXT_FIRST   = 5'd1;
    localparam logic [4:0] EXT_LAST    = 5'd3;
    localparam logic [4:0] EXT_OFFSET  = 5'd14;

    localparam logic [12:0] BITRATE_UNIT = 13'd8000;
    localparam logic [15:0] SPK_ALL      = 16'hffff;

    // byte position inside a three-byte descriptor
    typedef enum logic [1:0] {
        PH_BYTE0 = 2'd0,
        PH_BYTE1 = 2'd1,
        PH_BYTE2 = 2'd2
    } phase_t;

    // result fields, last field (status) in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] speaker_mask;
        logic [8:0]  sync_delay;
        logic [15:0] format_mask;
        logic [20:0] max_bitrate;
        logic [2:0]  low_code;
        logic [12:0] rate_mask;
        logic [3:0]  channel_count;
        logic [4:0]  coding_type;
        logic [3:0]  sad_index;
        logic [1:0]  status;
    } result_t;

    // one queued output beat
    typedef struct packed {
        logic    is_summary;
        logic    last_of_run;
        result_t data;
    } entry_t;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

endpackage

// ===== rtl/eadp_sad_decode.sv =====
// Decodes one three-byte short audio descriptor into a result record.
// Depends on eadp_pkg.
module eadp_sad_decode
(
    input  logic [7:0]       b0,
    input  logic [7:0]       b1,
    input  logic [7:0]       b2,
    input  logic [3:0]       index,
    output logic [3:0]       raw_format,
    output eadp_pkg::result_t rec
);
    import eadp_pkg::*;

    logic [3:0] fmt;
    logic [4:0] ext;
    logic [4:0] code;

    assign fmt        = b0[6:3];
    assign ext        = b2[7:3];
    assign raw_format = fmt;

    // extended types 1 to 3 map to codes 15 to 17; other extended types give code 0
    always_comb
    begin
        code = {1'b0, fmt};
        if (fmt == FMT_EXT)
        begin
            if (ext >= EXT_FIRST && ext <= EXT_LAST)
                code = ext + EXT_OFFSET;
            else
                code = 5'd0;
        end
    end

    // record fields
    always_comb
    begin
        rec               = '0;
        rec.sad_index     = index;
        rec.coding_type   = code;
        rec.channel_count = {1'b0, b0[2:0]} + 4'd1;
        rec.rate_mask     = {b1[6], b1[5], b1[4], b1[3], 1'b0, b1[2], b1[1], b1[0], 5'b0};
        if (fmt == FMT_LPCM || fmt == FMT_WMA_PRO)
            rec.low_code = b2[2:0];
        if (fmt >= FMT_CMP_LO && fmt <= FMT_CMP_HI)
            rec.max_bitrate = {13'b0, b2} * {8'b0, BITRATE_UNIT};
    end

endmodule

// ===== rtl/eld_audio_descriptor_parser.sv =====
// Top level of the ELD audio descriptor parser: header tracking, result queue.
// Depends on eadp_pkg and eadp_sad_decode.
//
// Usage: ELD bytes come in on the s_axis channel one beat per byte, byte zero
// first, with s_axis_tlast on the final byte of the block. Each complete
// short audio descriptor yields one descriptor record on m_axis; the final
// byte yields a summary record (m_axis_tuser high). When one byte causes both,
// the descriptor record goes first and m_axis_tlast marks the last record of
// that byte.
// A record is written into the result queue when its byte is accepted and leaves it on m_axis in order.
// Throughput: one byte per cycle; a byte is taken while a four-entry result
// queue has room for two records, so the block only slows when the receiver
// stalls and the queue fills, and it never drops or repeats a record.
// Reset clears the header state, the byte position and the queue; after each
// final byte the header state starts over for the next block.
module eld_audio_descriptor_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_block
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // status, sad_index, coding_type, channel_count,
                                        // rate_mask, low_code, max_bitrate,
                                        // format_mask, sync_delay, speaker_mask, zero pad
    output logic        m_axis_tuser,   // is_summary
    output logic        m_axis_tlast    // last_of_run
);
    import eadp_pkg::*;

    // block state
    logic [POS_W-1:0] pos_reg;
    logic [4:0]       ver_reg;
    logic [4:0]       name_reg;
    logic [3:0]       count_reg;
    logic [7:0]       delay_reg;
    logic [6:0]       spk_reg;
    logic [15:0]      formats_reg;
    logic [4:0]       done_reg;
    phase_t           phase_reg;
    logic [7:0]       sad_b0_reg;
    logic [7:0]       sad_b1_reg;

    // result queue
    entry_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     fifo_count_reg;

    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic [4:0]  ver_now;
    logic [4:0]  name_now;
    logic [3:0]  count_now;
    logic [7:0]  delay_now;
    logic [6:0]  spk_now;
    logic [5:0]  start;
    logic        hdr_ok;
    logic        sad_active;
    logic        sad_emit;
    logic [3:0]  raw_format;
    result_t     sad_rec;
    logic [15:0] formats_now;
    logic [9:0]  size;
    logic [6:0]  sad_end;
    logic [1:0]  status;
    result_t     sum_rec;
    entry_t      first_entry;
    entry_t      second_entry;
    logic [1:0]  n_push;
    phase_t      phase_next;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;
    assign b      = s_axis_tdata;

    // header fields including the byte on the input this cycle
    assign ver_now   = (pos_reg == POS_VERSION)  ? b[7:3] : ver_reg;
    assign name_now  = (pos_reg == POS_NAME_LEN) ? b[4:0] : name_reg;
    assign count_now = (pos_reg == POS_SAD_CNT)  ? b[7:4] : count_reg;
    assign delay_now = (pos_reg == POS_DELAY)    ? b      : delay_reg;
    assign spk_now   = (pos_reg == POS_SPEAKER)  ? b[6:0] : spk_reg;

    assign start  = 6'(HEADER_BYTES) + {1'b0, name_now};
    assign hdr_ok = (ver_now == VER_861D || ver_now == VER_PARTIAL) &&
                    ({1'b0, name_now} <= 6'(NAME_MAX));

    // descriptor area tracking
    assign sad_active = (pos_reg >= {3'b0, start}) && hdr_ok && (done_reg < {1'b0, count_now});
    assign sad_emit   = sad_active && (phase_reg == PH_BYTE2);

    always_comb
    begin
        case (phase_reg)
            PH_BYTE0: phase_next = PH_BYTE1;
            PH_BYTE1: phase_next = PH_BYTE2;
            PH_BYTE2: phase_next = PH_BYTE0;
            default:  phase_next = PH_BYTE0;
        endcase
    end

    eadp_sad_decode u_sad_decode
    (
        .b0         (sad_b0_reg),
        .b1         (sad_b1_reg),
        .b2         (b),
        .index      (done_reg[3:0]),
        .raw_format (raw_format),
        .rec        (sad_rec)
    );

    assign formats_now = formats_reg | (sad_emit ? (16'd1 << raw_format) : 16'd0);

    // summary status
    assign size    = {1'b0, pos_reg} + 10'd1;
    assign sad_end = {1'b0, start} + {2'b0, count_now, 1'b0} + {3'b0, count_now};

    always_comb
    begin
        if (!(ver_now == VER_861D || ver_now == VER_PARTIAL))
            status = ST_BAD_VER;
        else if ({1'b0, name_now} > 6'(NAME_MAX) || size < {4'b0, start})
            status = ST_BAD_NAME;
        else if (size < {3'b0, sad_end})
            status = ST_TRUNCATED;
        else
            status = ST_VALID;
    end

    always_comb
    begin
        sum_rec              = '0;
        sum_rec.status       = status;
        sum_rec.sad_index    = count_now;
        sum_rec.format_mask  = formats_now;
        sum_rec.sync_delay   = {delay_now, 1'b0};
        sum_rec.speaker_mask = (status == ST_VALID && spk_now == 7'd0) ? SPK_ALL
                                                                        : {9'b0, spk_now};
    end

    // records to queue for this beat
    always_comb
    begin
        second_entry.is_summary  = 1'b1;
        second_entry.last_of_run = 1'b1;
        second_entry.data        = sum_rec;
        if (sad_emit)
        begin
            first_entry.is_summary  = 1'b0;
            first_entry.last_of_run = !s_axis_tlast;
            first_entry.data        = sad_rec;
        end
        else
        begin
            first_entry = second_entry;
        end
        n_push = accept ? ({1'b0, sad_emit} + {1'b0, s_axis_tlast}) : 2'd0;
    end

    // block state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            ver_reg     <= '0;
            name_reg    <= '0;
            count_reg   <= '0;
            delay_reg   <= '0;
            spk_reg     <= '0;
            formats_reg <= '0;
            done_reg    <= '0;
            phase_reg   <= PH_BYTE0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                pos_reg     <= '0;
                ver_reg     <= '0;
                name_reg    <= '0;
                count_reg   <= '0;
                delay_reg   <= '0;
                spk_reg     <= '0;
                formats_reg <= '0;
                done_reg    <= '0;
                phase_reg   <= PH_BYTE0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                    pos_reg <= pos_reg + 9'd1;
                ver_reg     <= ver_now;
                name_reg    <= name_now;
                count_reg   <= count_now;
                delay_reg   <= delay_now;
                spk_reg     <= spk_now;
                formats_reg <= formats_now;
                if (sad_active)
                    phase_reg <= phase_next;
                if (sad_emit)
                    done_reg <= done_reg + 5'd1;
            end
        end
    end

    // first two bytes of the current descriptor
    always_ff @(posedge clk)
    begin
        if (accept && sad_active && phase_reg == PH_BYTE0)
            sad_b0_reg <= b;
        if (accept && sad_active && phase_reg == PH_BYTE1)
            sad_b1_reg <= b;
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            fifo_reg[wr_ptr_reg] <= first_entry;
        if (n_push == 2'd2)
            fifo_reg[wr_ptr_reg + 2'd1] <= second_entry;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + n_push;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            fifo_count_reg <= fifo_count_reg + {1'b0, n_push} - {2'b0, pop};
        end
    end

    assign s_axis_tready = fifo_count_reg <= 3'(FIFO_DEPTH - 2);
    assign m_axis_tvalid = fifo_count_reg != '0;
    assign m_axis_tdata  = fifo_reg[rd_ptr_reg].data;
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].is_summary;
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].last_of_run;

    // checks
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= 3'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg <= {1'b0, count_reg})
        else $error("more descriptors decoded than declared");

    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> pos_reg == '0 && formats_reg == '0 && done_reg == '0)
        else $error("block state not cleared after final byte");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> m_axis_tvalid)
        else $error("summary record missing");

endmodule
